### sv/stq_pkg.sv
`timescale 1ns / 1ps

package stq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int MAX_FIRE      = 16;
	localparam int FIRE_CNT_W    = $clog2(MAX_FIRE + 1);

	// command codes
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_FIRED  = 2'd0;
	localparam logic [1:0] KIND_ADDED  = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_FULL   = 2'd3;

	// one stored timer
	typedef struct packed {
		logic        valid;
		logic [31:0] due;
		logic [23:0] period;
		logic        rep;
		logic [7:0]  tag;
		logic [15:0] id;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_POP
	} cell_op_t;

	// broadcast control to every cell
	typedef struct packed {
		cell_op_t    op;
		entry_t      new_entry;
		logic [15:0] hid;
		logic [31:0] hdue;
	} cell_ctl_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

### sv/stq_if.sv
`timescale 1ns / 1ps

interface stq_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] delta_ticks;
	logic [23:0] delay_ticks;
	logic        repeat_req;
	logic [7:0]  callback_tag;
	logic [15:0] handle_id;
	logic [31:0] handle_due;

	modport source (output valid, command, delta_ticks, delay_ticks, repeat_req,
		callback_tag, handle_id, handle_due, input ready);
	modport sink (input valid, command, delta_ticks, delay_ticks, repeat_req,
		callback_tag, handle_id, handle_due, output ready);
endinterface

interface stq_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  tag_out;
	logic [15:0] id_out;
	logic [31:0] due_out;
	logic        found;
	logic        last;

	modport source (output valid, kind, tag_out, id_out, due_out, found, last,
		input ready);
	modport sink (input valid, kind, tag_out, id_out, due_out, found, last,
		output ready);
endinterface

### sv/stq_cell.sv
`timescale 1ns / 1ps

module stq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  stq_pkg::cell_ctl_t ctl,
	input  stq_pkg::entry_t    prev_ent,
	input  stq_pkg::entry_t    next_ent,
	input  logic               keep_in,
	input  logic               blk_in,
	input  logic               shift_in,
	output stq_pkg::entry_t    ent,
	output logic               keep_out,
	output logic               blk_out,
	output logic               shift_out
);
	import stq_pkg::*;

	entry_t ent_q;
	logic   id_hit;
	logic   match;

	// ordering and search chain terms
	assign keep_out  = ent_q.valid && (ent_q.due <= ctl.new_entry.due);
	assign id_hit    = ent_q.valid && (ent_q.id == ctl.hid);
	assign match     = (ctl.op == CELL_REMOVE) && id_hit && !blk_in;
	assign blk_out   = blk_in || id_hit || (ent_q.valid && (ent_q.due > ctl.hdue));
	assign shift_out = shift_in || match;
	assign ent       = ent_q;

	// entry update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.valid <= 1'b0;
		end else begin
			unique case (ctl.op)
				CELL_INSERT: begin
					if (!keep_out) begin
						ent_q <= keep_in ? ctl.new_entry : prev_ent;
					end
				end
				CELL_REMOVE, CELL_POP: begin
					if (shift_out) begin
						ent_q <= next_ent;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### sv/sorted_timer_queue_core.sv
`timescale 1ns / 1ps

// Sorted timer queue: a row of DEPTH cells keeps timers ordered by trigger time,
// the earliest in the first cell; insert and delete shift the row by one cell.
// An add or remove moves from the transfer in S_IDLE to S_EXEC, which waits while
// the output is occupied, and its result is registered as S_EXEC completes.
// A tick steps through S_FIRE and S_REARM for each fired timer (S_FIRE pops the
// head, S_REARM re-inserts a repeating timer, then S_FIRE checks the next), for up
// to MAX_FIRE (16) timers; a held fire that waits for the output stalls the
// sequence. A new command is taken only once the previous one is finished, but
// while its last result still waits at the output.

module sorted_timer_queue_core #(
	parameter int DEPTH = stq_pkg::DEPTH_DEFAULT
) (
	input logic       clk,
	input logic       arst_n,
	stq_cmd_if.sink   cmd,
	stq_res_if.source res
);
	import stq_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIRE, S_REARM} state_t;

	state_t                  state_q;
	logic [31:0]             world_q;
	logic [15:0]             next_id_q;
	logic [1:0]              op_q;
	logic [23:0]             delay_q;
	logic                    rep_q;
	logic [7:0]              tag_q;
	logic [15:0]             hid_q;
	logic [31:0]             hdue_q;
	entry_t                  pend_q;
	logic                    pend_v_q;
	logic [FIRE_CNT_W-1:0]   fire_cnt_q;

	logic                    res_valid_q;
	logic [1:0]              kind_q;
	logic [7:0]              tag_out_q;
	logic [15:0]             id_out_q;
	logic [31:0]             due_out_q;
	logic                    found_q;
	logic                    last_q;

	entry_t                  ent [DEPTH];
	entry_t                  prev_e [DEPTH];
	entry_t                  next_e [DEPTH];
	logic [DEPTH:0]          keep_c;
	logic [DEPTH:0]          blk_c;
	logic [DEPTH:0]          shift_c;
	cell_ctl_t               ctl;

	logic                    ofree;
	logic                    full;
	logic                    can_fire;
	logic                    fire_go;
	logic                    res_load;

	assign ofree    = !res_valid_q || res.ready;
	assign full     = ent[DEPTH-1].valid;
	assign can_fire = ent[0].valid && (ent[0].due < world_q)
		&& (fire_cnt_q < FIRE_CNT_W'(MAX_FIRE));
	assign fire_go  = !pend_v_q || ofree;
	assign res_load = ((state_q == S_EXEC) && ofree)
		|| ((state_q == S_FIRE) && fire_go && pend_v_q);

	// cell row control
	always_comb begin
		ctl.op                  = CELL_HOLD;
		ctl.hid                 = hid_q;
		ctl.hdue                = hdue_q;
		ctl.new_entry.valid     = 1'b1;
		ctl.new_entry.due       = sat_add(world_q, {8'd0, delay_q});
		ctl.new_entry.period    = rep_q ? delay_q : 24'd0;
		ctl.new_entry.rep       = rep_q;
		ctl.new_entry.tag       = tag_q;
		ctl.new_entry.id        = next_id_q;
		unique case (state_q)
			S_EXEC: begin
				if (ofree && op_q == CMD_ADD && !full) ctl.op = CELL_INSERT;
				if (ofree && op_q == CMD_REMOVE) ctl.op = CELL_REMOVE;
			end
			S_FIRE: begin
				if (fire_go && can_fire) ctl.op = CELL_POP;
			end
			S_REARM: begin
				ctl.new_entry.due    = sat_add(world_q, {8'd0, pend_q.period});
				ctl.new_entry.period = pend_q.period;
				ctl.new_entry.rep    = 1'b1;
				ctl.new_entry.tag    = pend_q.tag;
				if (pend_q.rep) ctl.op = CELL_INSERT;
			end
			default: begin
			end
		endcase
	end

	assign keep_c[0]  = 1'b1;
	assign blk_c[0]   = 1'b0;
	assign shift_c[0] = (ctl.op == CELL_POP);

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_e[i] = '0;
		end else begin : g_mid
			assign prev_e[i] = ent[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign next_e[i] = '0;
		end else begin : g_nxt
			assign next_e[i] = ent[i+1];
		end
		stq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.prev_ent  (prev_e[i]),
			.next_ent  (next_e[i]),
			.keep_in   (keep_c[i]),
			.blk_in    (blk_c[i]),
			.shift_in  (shift_c[i]),
			.ent       (ent[i]),
			.keep_out  (keep_c[i+1]),
			.blk_out   (blk_c[i+1]),
			.shift_out (shift_c[i+1])
		);
	end

	assign cmd.ready   = (state_q == S_IDLE);
	assign res.valid   = res_valid_q;
	assign res.kind    = kind_q;
	assign res.tag_out = tag_out_q;
	assign res.id_out  = id_out_q;
	assign res.due_out = due_out_q;
	assign res.found   = found_q;
	assign res.last    = last_q;

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			world_q     <= '0;
			next_id_q   <= '0;
			pend_v_q    <= 1'b0;
			fire_cnt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q    <= cmd.command;
						delay_q <= cmd.delay_ticks;
						rep_q   <= cmd.repeat_req;
						tag_q   <= cmd.callback_tag;
						hid_q   <= cmd.handle_id;
						hdue_q  <= cmd.handle_due;
						if (cmd.command == CMD_TICK) begin
							world_q    <= sat_add(world_q, {16'd0, cmd.delta_ticks});
							fire_cnt_q <= '0;
							pend_v_q   <= 1'b0;
							state_q    <= S_FIRE;
						end else if (cmd.command == CMD_ADD || cmd.command == CMD_REMOVE) begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					if (ofree) begin
						tag_out_q <= '0;
						found_q   <= (op_q == CMD_REMOVE) && shift_c[DEPTH];
						last_q    <= 1'b1;
						if (op_q == CMD_REMOVE) begin
							kind_q    <= KIND_REMOVE;
							id_out_q  <= '0;
							due_out_q <= '0;
						end else if (full) begin
							kind_q    <= KIND_FULL;
							id_out_q  <= '0;
							due_out_q <= '0;
						end else begin
							kind_q    <= KIND_ADDED;
							id_out_q  <= next_id_q;
							due_out_q <= ctl.new_entry.due;
							next_id_q <= next_id_q + 16'd1;
						end
						state_q <= S_IDLE;
					end
				end
				S_FIRE: begin
					if (fire_go) begin
						// send the held fire once we know whether more follow
						if (pend_v_q) begin
							kind_q      <= KIND_FIRED;
							tag_out_q   <= pend_q.tag;
							id_out_q    <= pend_q.id;
							due_out_q   <= pend_q.due;
							found_q     <= 1'b0;
							last_q      <= !can_fire;
						end
						if (can_fire) begin
							pend_q     <= ent[0];
							pend_v_q   <= 1'b1;
							fire_cnt_q <= fire_cnt_q + 1'b1;
							state_q    <= S_REARM;
						end else begin
							pend_v_q <= 1'b0;
							state_q  <= S_IDLE;
						end
					end
				end
				S_REARM: begin
					if (pend_q.rep) next_id_q <= next_id_q + 16'd1;
					state_q <= S_FIRE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		ent[DEPTH-1].valid |-> ent[0].valid)
		else $error("last cell valid while head empty");
	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= FIRE_CNT_W'(MAX_FIRE))
		else $error("fire count beyond limit");
	a_found_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind != KIND_REMOVE) |-> !res.found)
		else $error("found set on non-remove result");
	a_rearm_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REARM) |-> $past(ctl.op == CELL_POP))
		else $error("re-arm without a pop");
`endif

endmodule
